@@ sv/upd_pkg.sv @@
// Shared types, constants and character helpers for the URL percent decoder.
// No dependencies; imported by every module of the block.
package upd_pkg;

   localparam logic [7:0] PCT_CHAR = 8'h25;
   localparam int         MAX_OUT  = 3;

   typedef enum logic [2:0] {
      PEND_NONE = 3'b001,
      PEND_PCT  = 3'b010,
      PEND_DIG  = 3'b100
   } pend_type;

   typedef struct packed {
      logic [1:0]                 count;
      logic [MAX_OUT-1:0][7:0]    bytes;
      logic                       last;
   } cmd_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) ||
             (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = c - 8'h61 + 8'd10;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = c - 8'h41 + 8'd10;
      end
      return v[3:0];
   endfunction

endpackage

@@ sv/url_percent_decoder.sv @@
// URL percent decoder: one input word per cycle while the queue has room.
// Latency: a result shows on the rsp_ ports at the earliest the cycle after its input word.
// Throughput: one result word per cycle from the back end while rsp_pop is high and
// results wait; an input word yields zero to three results, so the command queue of
// DEPTH entries sets how long the input side runs ahead. Synchronous reset empties the
// queue and drops any pending escape.
module url_percent_decoder #(
   parameter int DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_byte,
   input  logic       req_end,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_byte,
   output logic       rsp_run_end,
   output logic       rsp_string_end
);
   import upd_pkg::*;

   logic    accept;
   logic    cmd_valid;
   cmd_type cmd;
   logic    q_empty;
   cmd_type q_head;
   logic    q_pop;

   assign accept = req_push && !req_full;

   upd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_byte),
      .in_end    (req_end),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   upd_queue #(.DEPTH(DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_valid),
      .push_data (cmd),
      .full      (req_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   upd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (!q_empty),
      .head           (q_head),
      .head_pop       (q_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_byte       (rsp_byte),
      .rsp_run_end    (rsp_run_end),
      .rsp_string_end (rsp_string_end)
   );

   assert property (@(posedge clock) disable iff (reset)
      accept && req_end |=> !rsp_empty)
      else $error("end word left no result waiting");

endmodule

@@ sv/upd_front.sv @@
// Front end: tracks the pending escape and turns each input word into a
// command of zero to three output bytes. Depends on upd_pkg.
module upd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       in_byte,
   input  logic             in_end,
   output logic             cmd_valid,
   output upd_pkg::cmd_type cmd
);
   import upd_pkg::*;

   pend_type   pend_ff, pend_in;
   logic [7:0] held_ff, held_in;

   always_comb begin
      logic [1:0]              n;
      logic [MAX_OUT-1:0][7:0] bytes;
      pend_type                pend;
      logic                    fresh;
      n     = 2'd0;
      bytes = '0;
      pend  = pend_ff;
      fresh = 1'b0;
      held_in = held_ff;
      unique case (pend_ff)
         PEND_PCT: begin
            if (is_hex(in_byte)) begin
               held_in = in_byte;
               pend    = PEND_DIG;
            end else begin
               bytes[n] = PCT_CHAR;
               n        = n + 2'd1;
               fresh    = 1'b1;
            end
         end
         PEND_DIG: begin
            if (is_hex(in_byte)) begin
               bytes[n] = {hex_value(held_ff), hex_value(in_byte)};
               n        = n + 2'd1;
               pend     = PEND_NONE;
            end else begin
               bytes[n] = PCT_CHAR;
               n        = n + 2'd1;
               bytes[n] = held_ff;
               n        = n + 2'd1;
               fresh    = 1'b1;
            end
         end
         default: begin
            fresh = 1'b1;
         end
      endcase
      if (fresh) begin
         if (in_byte == PCT_CHAR) begin
            pend = PEND_PCT;
         end else begin
            pend     = PEND_NONE;
            bytes[n] = in_byte;
            n        = n + 2'd1;
         end
      end
      if (in_end) begin
         if (pend == PEND_PCT) begin
            bytes[n] = PCT_CHAR;
            n        = n + 2'd1;
         end else if (pend == PEND_DIG) begin
            bytes[n] = PCT_CHAR;
            n        = n + 2'd1;
            bytes[n] = held_in;
            n        = n + 2'd1;
         end
         pend = PEND_NONE;
      end
      pend_in   = pend;
      cmd.count = n;
      cmd.bytes = bytes;
      cmd.last  = in_end;
      cmd_valid = accept && (n != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= PEND_NONE;
         held_ff <= 8'h00;
      end else if (accept) begin
         pend_ff <= pend_in;
         held_ff <= held_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      accept && in_end |-> cmd_valid)
      else $error("end word produced no command");

endmodule

@@ sv/upd_queue.sv @@
// Short command queue between front and back end.
// Depends on upd_pkg for the command word type.
module upd_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  upd_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output upd_pkg::cmd_type head
);
   import upd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count overflow");

   assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> !empty && count_ff == $past(count_ff) + CNT_W'(1))
      else $error("queue count lost a push");

endmodule

@@ sv/upd_back.sv @@
// Back end: walks the head command byte by byte onto the result port.
// Depends on upd_pkg for the command word type.
module upd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  upd_pkg::cmd_type head,
   output logic             head_pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output logic [7:0]       rsp_byte,
   output logic             rsp_run_end,
   output logic             rsp_string_end
);
   import upd_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       last_byte;

   assign last_byte      = (idx_ff == head.count - 2'd1);
   assign rsp_empty      = !head_valid;
   assign rsp_byte       = head.bytes[idx_ff];
   assign rsp_run_end    = last_byte;
   assign rsp_string_end = last_byte && head.last;
   assign head_pop       = rsp_pop && head_valid && last_byte;

   always_comb begin
      idx_in = idx_ff;
      if (rsp_pop && head_valid) begin
         idx_in = last_byte ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      head_valid |-> idx_ff < head.count)
      else $error("byte index beyond command length");

endmodule
